// ----- hw/rtl/longest_window_exact_ones_defines.svh -----
// Assertion macros for the longest_window_exact_ones checker.
// Included by the checker file; no other dependencies.
`ifndef LONGEST_WINDOW_EXACT_ONES_DEFINES_SVH
`define LONGEST_WINDOW_EXACT_ONES_DEFINES_SVH

// Property checked outside reset
`define LWE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included
`define LWE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/lwe_pkg.sv -----
// Shared constants for the longest_window_exact_ones block.
// No dependencies; used by the top level.
package lwe_pkg;

    // sequence length limit and ring of one-positions
    localparam int unsigned MAX_LEN    = 65535;
    localparam int unsigned RING_DEPTH = 1024;
    localparam int unsigned RING_AW    = $clog2(RING_DEPTH);

    // field widths
    localparam int unsigned POS_W = 16;
    localparam int unsigned TGT_W = 10;

    // largest target the ring can serve
    localparam logic [TGT_W-1:0] TGT_MAX = TGT_W'(RING_DEPTH - 1);

endpackage

// ----- hw/rtl/longest_window_exact_ones.sv -----
// Longest window with a given number of ones; streaming top level.
// Depends on lwe_pkg for widths, limits and the ring depth.
//
// Usage:
//   s_ channel carries one sequence bit per word (s_tdata[0]); s_tlast marks
//   the final bit of a sequence. m_ channel carries one word per sequence:
//   m_tdata[15:0] is the removal count, m_tuser[0] impossible, m_tuser[1]
//   overflow. cfg_we/cfg_wdata set the target number of ones; write it
//   only while no sequence is in flight.
// Throughput: one bit per cycle, back to back, while s_tready is high. Each
//   bit does one write and one read of the one-position ring, a
//   single-port-per-direction memory with a registered read; a bit that
//   reads the entry it writes takes the written position by forwarding.
// Result: the word marked last passes the lookup register, then loads the
//   output register once that register is free.
// Stall: the output register holds its word while m_tready is low; the bit
//   stream keeps flowing until a second finished sequence is waiting behind
//   it, then s_tready drops until the output drains.
// Reset: aresetn clears counters, pipeline and target (target 0). The ring
//   needs no clearing pass; only entries written in the current sequence
//   are used.
module longest_window_exact_ones (
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration
    input  logic                      cfg_we,
    input  logic [lwe_pkg::TGT_W-1:0] cfg_wdata,   // target_ones
    // input stream
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,     // [0] bit_value, [7:1] zero
    input  logic                      s_tlast,     // last_flag
    // result stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [15:0]               m_tdata,     // [15:0] removals
    output logic [1:0]                m_tuser      // [0] impossible, [1] overflow
);

    localparam int unsigned POS_W   = lwe_pkg::POS_W;
    localparam int unsigned RING_AW = lwe_pkg::RING_AW;
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(lwe_pkg::MAX_LEN);

    // lookup stage: control and payload riding along with the ring read
    typedef struct packed {
        logic             valid;
        logic             last;
        logic             qual;     // ones reached target, window counts
        logic             kzero;    // window starts at sequence head
        logic             fwd;      // read hits the entry written this word
        logic             imp;
        logic             ovf;
        logic [POS_W-1:0] pos;
    } look_t;

    logic [lwe_pkg::TGT_W-1:0] target_reg;
    logic [POS_W-1:0]          pos_reg, pos_next;
    logic [POS_W-1:0]          ones_reg, ones_next;
    logic                      ovf_reg, ovf_next;
    logic [POS_W-1:0]          best_reg, best_next;
    look_t                     look_reg, look_next;

    logic [POS_W-1:0]          ring [lwe_pkg::RING_DEPTH];
    logic [POS_W-1:0]          rdata_reg;

    logic                      out_valid_reg, out_valid_next;
    logic [15:0]               out_rem_reg;
    logic                      out_imp_reg, out_ovf_reg;

    logic                      s_accept, out_free, look_adv, out_load;
    logic                      dropped, wr_en, ovf_now;
    logic [POS_W-1:0]          pos_new, ones_new, k_val, tgt_ext;
    logic [RING_AW-1:0]        wr_addr, rd_addr;
    logic [POS_W-1:0]          start_pos, win_len, best_cand, rem_val;

    // handshake: lookup stage stalls only on a finished sequence
    assign out_free = !out_valid_reg || m_tready;
    assign look_adv = look_reg.valid && (!look_reg.last || out_free);
    assign s_tready = !look_reg.valid || look_adv;
    assign s_accept = s_tvalid && s_tready;
    assign out_load = look_adv && look_reg.last;

    // front stage: counters, ring write and read address
    always_comb begin
        tgt_ext  = POS_W'(target_reg);
        dropped  = (pos_reg >= MAX_POS);
        pos_new  = dropped ? pos_reg : pos_reg + POS_W'(1);
        ones_new = (!dropped && s_tdata[0]) ? ones_reg + POS_W'(1) : ones_reg;
        k_val    = ones_new - tgt_ext;
        wr_en    = s_accept && !dropped && s_tdata[0];
        wr_addr  = ones_new[RING_AW-1:0];
        rd_addr  = k_val[RING_AW-1:0];
        ovf_now  = ovf_reg || dropped;

        look_next.valid = 1'b1;
        look_next.last  = s_tlast;
        look_next.qual  = !dropped && (ones_new >= tgt_ext);
        look_next.kzero = (k_val == '0);
        look_next.fwd   = wr_en && (wr_addr == rd_addr);
        look_next.imp   = (ones_new < tgt_ext);
        look_next.ovf   = ovf_now;
        look_next.pos   = pos_new;

        pos_next  = pos_reg;
        ones_next = ones_reg;
        ovf_next  = ovf_reg;
        if (s_accept) begin
            pos_next  = s_tlast ? '0 : pos_new;
            ones_next = s_tlast ? '0 : ones_new;
            ovf_next  = s_tlast ? 1'b0 : ovf_now;
        end
    end

    // lookup stage: window length and best so far
    always_comb begin
        if (look_reg.kzero) begin
            start_pos = '0;
        end else if (look_reg.fwd) begin
            start_pos = look_reg.pos;
        end else begin
            start_pos = rdata_reg;
        end
        win_len   = (start_pos <= look_reg.pos) ? look_reg.pos - start_pos : '0;
        best_cand = (look_reg.qual && win_len > best_reg) ? win_len : best_reg;
        rem_val   = look_reg.imp ? '0 : look_reg.pos - best_cand;

        best_next = best_reg;
        if (look_adv) begin
            best_next = look_reg.last ? '0 : best_cand;
        end
    end

    // output register valid
    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // control registers and lookup stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg     <= '0;
            pos_reg        <= '0;
            ones_reg       <= '0;
            ovf_reg        <= 1'b0;
            best_reg       <= '0;
            look_reg.valid <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                target_reg <= (cfg_wdata > lwe_pkg::TGT_MAX) ? lwe_pkg::TGT_MAX : cfg_wdata;
            end
            pos_reg       <= pos_next;
            ones_reg      <= ones_next;
            ovf_reg       <= ovf_next;
            best_reg      <= best_next;
            out_valid_reg <= out_valid_next;
            if (s_accept) begin
                look_reg <= look_next;
            end else if (look_adv) begin
                look_reg.valid <= 1'b0;
            end
        end
    end

    // ring of one-positions; read data holds while the front stage waits
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring[wr_addr] <= pos_new;
        end
        if (s_accept) begin
            rdata_reg <= ring[rd_addr];
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_rem_reg <= 16'(rem_val);
            out_imp_reg <= look_reg.imp;
            out_ovf_reg <= look_reg.ovf;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_rem_reg;
    assign m_tuser  = {out_ovf_reg, out_imp_reg};

endmodule

// ----- hw/rtl/lwe_checker.sv -----
// Port-level checker for longest_window_exact_ones, bound to the top level.
// Depends on longest_window_exact_ones_defines.svh.
`include "longest_window_exact_ones_defines.svh"

module lwe_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // a stalled result word holds
    `LWE_ASSERT(a_out_hold, aclk, aresetn,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser),
        "result word changed while stalled")

    // an impossible sequence reports zero removals
    `LWE_ASSERT(a_imp_zero, aclk, aresetn,
        m_tvalid && m_tuser[0] |-> m_tdata == 16'd0,
        "impossible result with nonzero removals")

    // a fresh result is preceded by an accepted last word
    `LWE_ASSERT(a_out_after_last, aclk, aresetn,
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2),
        "result word without a preceding last word")

    // reset empties the output
    `LWE_ASSERT_ALWAYS(a_reset_empty, aclk,
        !aresetn |=> !m_tvalid,
        "result valid after reset")

endmodule

bind longest_window_exact_ones lwe_checker u_lwe_checker (.*);
